@@ hw/rtl/lgme_pkg.sv @@
// Shared constants for the mirror-edge Life generation unit.
// No dependencies; used by life_generation_mirror_edge_unit.
`default_nettype none

package lgme_pkg;

  // board dimensions
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // end reasons
  localparam logic [2:0] RSN_NONE   = 3'd0;
  localparam logic [2:0] RSN_EXTINCT = 3'd1;
  localparam logic [2:0] RSN_OSC    = 3'd2;
  localparam logic [2:0] RSN_STABLE = 3'd3;
  localparam logic [2:0] RSN_GENLIM = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ROWS    = 3'd0;
  localparam logic [2:0] CFG_COLS    = 3'd1;
  localparam logic [2:0] CFG_GEN_LIM = 3'd2;
  localparam logic [2:0] CFG_STB_LIM = 3'd3;
  localparam logic [2:0] CFG_OSC_LIM = 3'd4;

  // reset values of the configuration registers
  localparam logic [6:0]  RST_ROWS    = 7'd64;
  localparam logic [6:0]  RST_COLS    = 7'd64;
  localparam logic [15:0] RST_GEN_LIM = 16'd1000;
  localparam logic [7:0]  RST_STB_LIM = 8'd5;
  localparam logic [7:0]  RST_OSC_LIM = 8'd10;

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_CMD_RD  = 10'b0000000100,
    S_CMD_MOD = 10'b0000001000,
    S_ROW     = 10'b0000010000,
    S_LOAD    = 10'b0000100000,
    S_CELL    = 10'b0001000000,
    S_WRITE   = 10'b0010000000,
    S_FINISH  = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/life_generation_mirror_edge_unit.sv @@
// Mirror-edge Life (B3/S23) board with history tracking and run end checks.
// Depends on lgme_pkg (board size, commands, reasons, register indexes, state type).
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, cmd, row, col, cell_in | into block
//  out     | out_valid/out_ready, cell_out, status     | out of block
//  cfg     | cfg_we, cfg_index, cfg_data               | into block, write only
//
// After reset a clearing pass zeroes the three boards, one row at a time.
// A write or read in the area goes through S_CMD_RD and S_CMD_MOD to S_DONE;
// a step on a run not yet ended walks all MAX_ROWS rows through one cell-update
// unit, and any other command goes straight to S_DONE. An unused row is cleared
// in S_ROW; a row in use passes S_ROW (row pick), S_LOAD (4 row reads on the
// single read port), S_CELL (one cell per cycle) and S_WRITE (one write).
// A waiting result sits in the output register; the next transfer waits only
// for that register to drain.
`default_nettype none

module life_generation_mirror_edge_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_row,
  input  wire logic [5:0]  in_col,
  input  wire logic        in_cell_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_cell_out,
  output logic [12:0]      out_population,
  output logic [15:0]      out_generation,
  output logic             out_run_ended,
  output logic [2:0]       out_end_reason,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int RW  = $clog2(lgme_pkg::MAX_ROWS);
  localparam int CW  = $clog2(lgme_pkg::MAX_COLS);
  localparam int RCW = $clog2(lgme_pkg::MAX_ROWS + 1);
  localparam int CCW = $clog2(lgme_pkg::MAX_COLS + 1);

  // board storage: three banks rotating through now / before / two-back
  logic [lgme_pkg::MAX_COLS-1:0] board_mem [3][lgme_pkg::MAX_ROWS];
  logic [lgme_pkg::MAX_COLS-1:0] rd_data_r;
  logic                mem_we;
  logic [1:0]          mem_wbank, mem_rbank;
  logic [RW-1:0]       mem_wrow, mem_rrow;
  logic [lgme_pkg::MAX_COLS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      board_mem[mem_wbank][mem_wrow] <= mem_wdata;
    end
    rd_data_r <= board_mem[mem_rbank][mem_rrow];
  end

  lgme_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [2:0]          ld_cnt_r, ld_cnt_nxt;
  logic [1:0]          clr_bank_r, clr_bank_nxt;
  logic [1:0]          now_b_r, now_b_nxt, bef_b_r, bef_b_nxt;
  logic [1:0]          free_b;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [RW-1:0]       crow_r, crow_nxt;
  logic [CW-1:0]       ccol_r, ccol_nxt;
  logic                cval_r, cval_nxt;
  logic [lgme_pkg::MAX_COLS-1:0] up_r, up_nxt, mid_r, mid_nxt;
  logic [lgme_pkg::MAX_COLS-1:0] dn_r, dn_nxt, old_r, old_nxt;
  logic [lgme_pkg::MAX_COLS-1:0] new_row_r, new_row_nxt;
  logic [12:0]         pop_r, pop_nxt, live_r, live_nxt;
  logic                same1_r, same1_nxt, same2_r, same2_nxt;
  logic [15:0]         gen_r, gen_nxt;
  logic [7:0]          stable_r, stable_nxt, repeat_r, repeat_nxt;
  logic                ended_r, ended_nxt, cell_r, cell_nxt;
  logic [2:0]          reason_r, reason_nxt;
  logic                out_valid_r, out_cell_r;
  logic [12:0]         out_pop_r;
  logic [15:0]         out_gen_r;
  logic                out_ended_r;
  logic [2:0]          out_reason_r;
  logic [6:0]          cfg_rows_r, cfg_cols_r;
  logic [15:0]         cfg_gen_lim_r;
  logic [7:0]          cfg_stb_lim_r, cfg_osc_lim_r;

  logic [RCW-1:0] nr_c;
  logic [CCW-1:0] nc_c;
  logic           in_xfer, in_area, out_free, row_last, row_used;
  logic [RW-1:0]  up_row, dn_row;
  logic [CW-1:0]  lcol, rcol;
  logic [3:0]     cnt;
  logic           nbit;
  logic [7:0]     stable_inc, repeat_inc;
  logic [15:0]    gen_inc;

  // sizes clamp to 2..MAX
  always_comb begin
    if (cfg_rows_r < 7'd2) begin
      nr_c = RCW'(2);
    end else if (32'(cfg_rows_r) > 32'(lgme_pkg::MAX_ROWS)) begin
      nr_c = RCW'(lgme_pkg::MAX_ROWS);
    end else begin
      nr_c = RCW'(cfg_rows_r);
    end
    if (cfg_cols_r < 7'd2) begin
      nc_c = CCW'(2);
    end else if (32'(cfg_cols_r) > 32'(lgme_pkg::MAX_COLS)) begin
      nc_c = CCW'(lgme_pkg::MAX_COLS);
    end else begin
      nc_c = CCW'(cfg_cols_r);
    end
  end

  assign in_ready = (state_r == lgme_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_area  = (32'(in_row) < 32'(nr_c)) && (32'(in_col) < 32'(nc_c));
  assign out_free = !out_valid_r || out_ready;
  assign free_b   = 2'd3 - now_b_r - bef_b_r;
  assign row_last = (32'(row_r) == 32'(lgme_pkg::MAX_ROWS) - 32'd1);
  assign row_used = (32'(row_r) < 32'(nr_c));
  assign up_row   = (row_r == '0) ? row_r : RW'(row_r - 1'b1);
  assign dn_row   = (32'(row_r) == 32'(nr_c) - 32'd1) ? row_r : RW'(row_r + 1'b1);
  assign lcol     = (col_r == '0) ? col_r : CW'(col_r - 1'b1);
  assign rcol     = (32'(col_r) == 32'(nc_c) - 32'd1) ? col_r : CW'(col_r + 1'b1);

  // folded 3x3 neighbourhood of the current cell
  assign cnt = 4'(up_r[lcol]) + 4'(up_r[col_r]) + 4'(up_r[rcol])
             + 4'(mid_r[lcol]) + 4'(mid_r[rcol])
             + 4'(dn_r[lcol]) + 4'(dn_r[col_r]) + 4'(dn_r[rcol]);
  assign nbit = (cnt == 4'd3) || ((cnt == 4'd2) && mid_r[col_r]);

  assign stable_inc = (stable_r == 8'hFF) ? stable_r : stable_r + 8'd1;
  assign repeat_inc = (repeat_r == 8'hFF) ? repeat_r : repeat_r + 8'd1;
  assign gen_inc    = (gen_r == 16'hFFFF) ? gen_r : gen_r + 16'd1;

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    ld_cnt_nxt   = ld_cnt_r;
    clr_bank_nxt = clr_bank_r;
    now_b_nxt    = now_b_r;
    bef_b_nxt    = bef_b_r;
    cmd_nxt      = cmd_r;
    crow_nxt     = crow_r;
    ccol_nxt     = ccol_r;
    cval_nxt     = cval_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    dn_nxt       = dn_r;
    old_nxt      = old_r;
    new_row_nxt  = new_row_r;
    pop_nxt      = pop_r;
    live_nxt     = live_r;
    same1_nxt    = same1_r;
    same2_nxt    = same2_r;
    gen_nxt      = gen_r;
    stable_nxt   = stable_r;
    repeat_nxt   = repeat_r;
    ended_nxt    = ended_r;
    reason_nxt   = reason_r;
    cell_nxt     = cell_r;
    mem_we       = 1'b0;
    mem_wbank    = free_b;
    mem_wrow     = row_r;
    mem_wdata    = '0;
    mem_rbank    = now_b_r;
    mem_rrow     = crow_r;

    unique case (state_r)
      lgme_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wbank = clr_bank_r;
        if (row_last) begin
          row_nxt = '0;
          if (clr_bank_r == 2'd2) begin
            state_nxt = lgme_pkg::S_IDLE;
          end else begin
            clr_bank_nxt = clr_bank_r + 2'd1;
          end
        end else begin
          row_nxt = RW'(row_r + 1'b1);
        end
      end
      lgme_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt  = in_cmd;
          crow_nxt = RW'(in_row);
          ccol_nxt = CW'(in_col);
          cval_nxt = in_cell_in;
          cell_nxt = 1'b0;
          state_nxt = lgme_pkg::S_DONE;
          case (in_cmd)
            lgme_pkg::CMD_WRITE: begin
              gen_nxt    = '0;
              stable_nxt = '0;
              repeat_nxt = '0;
              ended_nxt  = 1'b0;
              reason_nxt = lgme_pkg::RSN_NONE;
              if (in_area) state_nxt = lgme_pkg::S_CMD_RD;
            end
            lgme_pkg::CMD_READ: begin
              if (in_area) state_nxt = lgme_pkg::S_CMD_RD;
            end
            lgme_pkg::CMD_STEP: begin
              if (!ended_r) begin
                state_nxt = lgme_pkg::S_ROW;
                row_nxt   = '0;
                pop_nxt   = '0;
                same1_nxt = 1'b1;
                same2_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      lgme_pkg::S_CMD_RD: begin
        // read address driven by default; data lands next cycle
        state_nxt = lgme_pkg::S_CMD_MOD;
      end
      lgme_pkg::S_CMD_MOD: begin
        if (cmd_r == lgme_pkg::CMD_WRITE) begin
          mem_we            = 1'b1;
          mem_wbank         = now_b_r;
          mem_wrow          = crow_r;
          mem_wdata         = rd_data_r;
          mem_wdata[ccol_r] = cval_r;
        end else begin
          cell_nxt = rd_data_r[ccol_r];
        end
        state_nxt = lgme_pkg::S_DONE;
      end
      lgme_pkg::S_ROW: begin
        if (row_used) begin
          state_nxt  = lgme_pkg::S_LOAD;
          ld_cnt_nxt = '0;
        end else begin
          // rows outside the area become dead
          mem_we = 1'b1;
          if (row_last) begin
            state_nxt = lgme_pkg::S_FINISH;
          end else begin
            row_nxt = RW'(row_r + 1'b1);
          end
        end
      end
      lgme_pkg::S_LOAD: begin
        case (ld_cnt_r)
          3'd0:    mem_rrow = up_row;
          3'd1:    mem_rrow = row_r;
          3'd2:    mem_rrow = dn_row;
          default: begin
            mem_rbank = bef_b_r;
            mem_rrow  = row_r;
          end
        endcase
        case (ld_cnt_r)
          3'd1:    up_nxt  = rd_data_r;
          3'd2:    mid_nxt = rd_data_r;
          3'd3:    dn_nxt  = rd_data_r;
          3'd4:    old_nxt = rd_data_r;
          default: ;
        endcase
        if (ld_cnt_r == 3'd4) begin
          state_nxt   = lgme_pkg::S_CELL;
          col_nxt     = '0;
          new_row_nxt = '0;
        end else begin
          ld_cnt_nxt = ld_cnt_r + 3'd1;
        end
      end
      lgme_pkg::S_CELL: begin
        new_row_nxt[col_r] = nbit;
        pop_nxt = pop_r + 13'(nbit);
        if (nbit != mid_r[col_r]) same1_nxt = 1'b0;
        if (nbit != old_r[col_r]) same2_nxt = 1'b0;
        if (32'(col_r) == 32'(nc_c) - 32'd1) begin
          state_nxt = lgme_pkg::S_WRITE;
        end else begin
          col_nxt = CW'(col_r + 1'b1);
        end
      end
      lgme_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = new_row_r;
        if (row_last) begin
          state_nxt = lgme_pkg::S_FINISH;
        end else begin
          row_nxt   = RW'(row_r + 1'b1);
          state_nxt = lgme_pkg::S_ROW;
        end
      end
      lgme_pkg::S_FINISH: begin
        // rotate banks: new board lives in the freed bank
        now_b_nxt  = free_b;
        bef_b_nxt  = now_b_r;
        live_nxt   = pop_r;
        stable_nxt = same1_r ? stable_inc : 8'd0;
        repeat_nxt = same2_r ? repeat_inc : 8'd0;
        gen_nxt    = gen_inc;
        if (pop_r == '0) begin
          ended_nxt  = 1'b1;
          reason_nxt = lgme_pkg::RSN_EXTINCT;
        end else if (repeat_nxt >= cfg_osc_lim_r) begin
          ended_nxt  = 1'b1;
          reason_nxt = lgme_pkg::RSN_OSC;
        end else if (stable_nxt >= cfg_stb_lim_r) begin
          ended_nxt  = 1'b1;
          reason_nxt = lgme_pkg::RSN_STABLE;
        end else if (gen_inc >= cfg_gen_lim_r) begin
          ended_nxt  = 1'b1;
          reason_nxt = lgme_pkg::RSN_GENLIM;
        end
        state_nxt = lgme_pkg::S_DONE;
      end
      lgme_pkg::S_DONE: begin
        if (out_free) state_nxt = lgme_pkg::S_IDLE;
      end
      default: state_nxt = lgme_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lgme_pkg::S_CLEAR;
      row_r      <= '0;
      clr_bank_r <= '0;
      now_b_r    <= 2'd0;
      bef_b_r    <= 2'd1;
      ld_cnt_r   <= '0;
      col_r      <= '0;
      cmd_r      <= '0;
      live_r     <= '0;
      gen_r      <= '0;
      stable_r   <= '0;
      repeat_r   <= '0;
      ended_r    <= 1'b0;
      reason_r   <= lgme_pkg::RSN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      clr_bank_r <= clr_bank_nxt;
      now_b_r    <= now_b_nxt;
      bef_b_r    <= bef_b_nxt;
      ld_cnt_r   <= ld_cnt_nxt;
      col_r      <= col_nxt;
      cmd_r      <= cmd_nxt;
      live_r     <= live_nxt;
      gen_r      <= gen_nxt;
      stable_r   <= stable_nxt;
      repeat_r   <= repeat_nxt;
      ended_r    <= ended_nxt;
      reason_r   <= reason_nxt;
      if ((state_r == lgme_pkg::S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crow_r    <= crow_nxt;
    ccol_r    <= ccol_nxt;
    cval_r    <= cval_nxt;
    up_r      <= up_nxt;
    mid_r     <= mid_nxt;
    dn_r      <= dn_nxt;
    old_r     <= old_nxt;
    new_row_r <= new_row_nxt;
    pop_r     <= pop_nxt;
    same1_r   <= same1_nxt;
    same2_r   <= same2_nxt;
    cell_r    <= cell_nxt;
    if ((state_r == lgme_pkg::S_DONE) && out_free) begin
      out_cell_r   <= cell_r;
      out_pop_r    <= live_r;
      out_gen_r    <= gen_r;
      out_ended_r  <= ended_r;
      out_reason_r <= reason_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r    <= lgme_pkg::RST_ROWS;
      cfg_cols_r    <= lgme_pkg::RST_COLS;
      cfg_gen_lim_r <= lgme_pkg::RST_GEN_LIM;
      cfg_stb_lim_r <= lgme_pkg::RST_STB_LIM;
      cfg_osc_lim_r <= lgme_pkg::RST_OSC_LIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgme_pkg::CFG_ROWS:    cfg_rows_r    <= cfg_data[6:0];
        lgme_pkg::CFG_COLS:    cfg_cols_r    <= cfg_data[6:0];
        lgme_pkg::CFG_GEN_LIM: cfg_gen_lim_r <= cfg_data;
        lgme_pkg::CFG_STB_LIM: cfg_stb_lim_r <= cfg_data[7:0];
        lgme_pkg::CFG_OSC_LIM: cfg_osc_lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = out_cell_r;
  assign out_population = out_pop_r;
  assign out_generation = out_gen_r;
  assign out_run_ended  = out_ended_r;
  assign out_end_reason = out_reason_r;

`ifndef ASSERT_OFF
  a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (now_b_r != bef_b_r) && (now_b_r != 2'd3) && (bef_b_r != 2'd3))
    else $error("board banks overlap");

  a_ended_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (reason_r != lgme_pkg::RSN_NONE))
    else $error("run ended without a reason");

  a_finish_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgme_pkg::S_FINISH) |=> (state_r == lgme_pkg::S_DONE))
    else $error("step finish did not report");

  a_no_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgme_pkg::S_CELL) |-> ##1 !(in_valid && in_ready) || $past(col_r) == col_r
      || (state_r == lgme_pkg::S_CELL) || (state_r == lgme_pkg::S_WRITE))
    else $error("input taken during a step");
`endif

endmodule

`default_nettype wire
